// File: hw/rtl/bcy_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcy_pkg
// Shared constants and types for the Bezier y-from-x evaluator.
// ----------------------------------------------------------------------------
package bcy_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_COEF_A   = 2'd0;
    localparam logic [1:0] CFG_COEF_B   = 2'd1;
    localparam logic [1:0] CFG_REVERSED = 2'd2;

    // Control that rides along with every pipeline beat
    typedef struct packed {
        logic vld;
        logic full;   // x saturated to one: t forced to one
    } bcy_tag_t;

endpackage

// File: hw/rtl/bcy_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcy_cell
// One bisection step: tries t with bit BIT set, keeps it when Bx(t) <= x.
// ----------------------------------------------------------------------------
module bcy_cell
#(
    parameter int F   = bcy_pkg::FRAC_BITS_DEF,
    parameter int BIT = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic signed [F+7:0]    c1,
    input  logic signed [F+7:0]    c2,
    input  logic signed [F+7:0]    c3,
    input  bcy_pkg::bcy_tag_t      tag_in,
    input  logic [F:0]             x_in,
    input  logic [F-1:0]           t_in,
    output bcy_pkg::bcy_tag_t      tag_out,
    output logic [F:0]             x_out,
    output logic [F-1:0]           t_out
);
    import bcy_pkg::*;

    localparam int CW = F + 8;
    localparam logic [F-1:0] BIT_MASK = {{(F-1){1'b0}}, 1'b1} << BIT;

    logic [F-1:0]           cand;
    logic signed [CW+F:0]   p1_next;
    logic signed [CW+1:0]   h1;
    logic signed [CW+F+2:0] p2_next;
    logic signed [CW+3:0]   h2;
    logic signed [CW+F+4:0] p3_next;
    logic signed [CW+4:0]   bx;
    logic                   keep;

    bcy_tag_t               tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic [F:0]             x1_reg, x2_reg, x3_reg, x4_reg;
    logic [F-1:0]           t1_reg, t2_reg, t3_reg, t4_reg;
    logic [F-1:0]           cand1_reg, cand2_reg, cand3_reg;
    logic signed [CW+F:0]   p1_reg;
    logic signed [CW+F+2:0] p2_reg;
    logic signed [CW+F+4:0] p3_reg;

    // Horner evaluation, one multiply per stage; arithmetic shift is floor
    assign cand    = t_in | BIT_MASK;
    assign p1_next = c3 * $signed({1'b0, cand});
    assign h1      = (CW+2)'(p1_reg >>> F) + (CW+2)'(c2);
    assign p2_next = h1 * $signed({1'b0, cand1_reg});
    assign h2      = (CW+4)'(p2_reg >>> F) + (CW+4)'(c1);
    assign p3_next = h2 * $signed({1'b0, cand2_reg});
    assign bx      = (CW+5)'(p3_reg >>> F);
    assign keep    = bx <= $signed((CW+5)'(x3_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end
        else if (en)
        begin
            tag1_reg <= tag_in;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg    <= x_in;
            t1_reg    <= t_in;
            cand1_reg <= cand;
            p1_reg    <= p1_next;
            x2_reg    <= x1_reg;
            t2_reg    <= t1_reg;
            cand2_reg <= cand1_reg;
            p2_reg    <= p2_next;
            x3_reg    <= x2_reg;
            t3_reg    <= t2_reg;
            cand3_reg <= cand2_reg;
            p3_reg    <= p3_next;
            x4_reg    <= x3_reg;
            t4_reg    <= keep ? cand3_reg : t3_reg;
        end
    end

    assign tag_out = tag4_reg;
    assign x_out   = x4_reg;
    assign t_out   = t4_reg;

endmodule

// File: hw/rtl/bcy_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcy_poly
// Ordinate y = 3t^2 - 2t^3 rounded, optional mirror 2x - y, output register.
// ----------------------------------------------------------------------------
module bcy_poly
#(
    parameter int F = bcy_pkg::FRAC_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                rev,
    input  bcy_pkg::bcy_tag_t   tag_in,
    input  logic [F:0]          x_in,
    input  logic [F-1:0]        t_in,
    output logic                vld_out,
    output logic signed [F+2:0] y_out,
    output logic [F:0]          t_out
);
    import bcy_pkg::*;

    localparam logic [F:0]     ONE       = {1'b1, {F{1'b0}}};
    localparam logic [F+2:0]   THREE_ONE = (F+3)'(3) << F;
    localparam logic [3*F+4:0] RND       = (3*F+5)'(1) << (2*F-1);

    logic [F:0]           t_full;
    logic [3*F+4:0]       rnd_sum;
    logic signed [F+2:0]  mirror;

    logic [3:0]           vld_reg;
    logic [F:0]           x1_reg, x2_reg, x3_reg, x4_reg;
    logic [F:0]           t1_reg, t2_reg, t3_reg, t4_reg;
    logic [2*F+1:0]       sq_reg;
    logic [F+2:0]         w_reg;
    logic [3*F+4:0]       prod_reg;
    logic signed [F+2:0]  y_reg;
    logic signed [F+2:0]  yo_reg;
    logic                 vo_reg;

    assign t_full  = tag_in.full ? ONE : {1'b0, t_in};
    assign rnd_sum = prod_reg + RND;
    assign mirror  = $signed((F+3)'({x4_reg, 1'b0})) - y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            vo_reg  <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], tag_in.vld};
            vo_reg  <= vld_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x_in;
            t1_reg   <= t_full;
            x2_reg   <= x1_reg;
            t2_reg   <= t1_reg;
            sq_reg   <= t1_reg * t1_reg;
            w_reg    <= THREE_ONE - (F+3)'({t1_reg, 1'b0});
            x3_reg   <= x2_reg;
            t3_reg   <= t2_reg;
            prod_reg <= sq_reg * w_reg;
            x4_reg   <= x3_reg;
            t4_reg   <= t3_reg;
            y_reg    <= $signed(rnd_sum[3*F+2:2*F]);
            yo_reg   <= rev ? mirror : y_reg;
            t_out    <= t4_reg;
        end
    end

    assign vld_out = vo_reg;
    assign y_out   = yo_reg;

endmodule

// File: hw/rtl/bezier_curve_y_from_x.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle while no output stall holds the pipe;
// each bisection cell spends four stages on its three Horner multiplies
// and the compare, and all cells run at once.
// The whole pipeline holds only while a finished result waits unaccepted.
// Reset (rst_n, async, active low) clears valids, config and coefficients.
// ----------------------------------------------------------------------------
// bezier_curve_y_from_x
// Cubic Bezier timing curve: finds t with Bx(t) = x by a chain of bisection
// cells, one per bit of t, then evaluates y = 3t^2 - 2t^3 (or 2x - y).
// ----------------------------------------------------------------------------
module bezier_curve_y_from_x
#(
    parameter int FRAC_BITS = bcy_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // config write port
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [FRAC_BITS+3:0]        cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [FRAC_BITS:0]          x_value,
    // output channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [FRAC_BITS+2:0] y_value,
    output logic [FRAC_BITS:0]          t_param
);
    import bcy_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int CW = F + 8;
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    // Config registers
    logic signed [F+3:0] coef_a_reg;
    logic [F:0]          coef_b_reg;
    logic                rev_reg;

    // Curve coefficients in Q.F, recomputed every cycle from the registers.
    // c1 = 3a, c2 = 3(b - 2a), c3 = 3a - 3b + 1
    logic signed [CW-1:0] a_ext, b_ext, d_ba;
    logic signed [CW-1:0] c1_next, c2_next, c3_next;
    logic signed [CW-1:0] c1_reg, c2_reg, c3_reg;

    // Input stage: saturate x and flag x == one
    logic                en;
    logic [F:0]          x_sat;
    bcy_tag_t            tag0_reg;
    logic [F:0]          x0_reg;

    // Cell chain links
    bcy_tag_t            tag_c [F+1];
    logic [F:0]          x_c   [F+1];
    logic [F-1:0]        t_c   [F+1];

    // The pipe moves unless the output register holds an untaken beat
    assign en       = ~out_valid | out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg <= '0;
            coef_b_reg <= '0;
            rev_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COEF_A:   coef_a_reg <= $signed(cfg_data);
                CFG_COEF_B:   coef_b_reg <= cfg_data[F:0];
                CFG_REVERSED: rev_reg    <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign a_ext   = CW'(coef_a_reg);
    assign b_ext   = $signed(CW'(coef_b_reg));
    assign d_ba    = b_ext - (a_ext <<< 1);
    assign c1_next = (a_ext <<< 1) + a_ext;
    assign c2_next = (d_ba <<< 1) + d_ba;
    assign c3_next = c1_next - ((b_ext <<< 1) + b_ext) + $signed(CW'(ONE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else
        begin
            c1_reg <= c1_next;
            c2_reg <= c2_next;
            c3_reg <= c3_next;
        end
    end

    assign x_sat = (x_value > ONE) ? ONE : x_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag0_reg <= '0;
        end
        else if (en)
        begin
            tag0_reg.vld  <= in_valid;
            tag0_reg.full <= (x_sat == ONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg <= x_sat;
        end
    end

    assign tag_c[0] = tag0_reg;
    assign x_c[0]   = x0_reg;
    assign t_c[0]   = '0;

    // One cell per bit of t, most significant first
    for (genvar k = 0; k < F; k++)
    begin : g_cell
        bcy_cell #(
            .F   (F),
            .BIT (F - 1 - k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .c1      (c1_reg),
            .c2      (c2_reg),
            .c3      (c3_reg),
            .tag_in  (tag_c[k]),
            .x_in    (x_c[k]),
            .t_in    (t_c[k]),
            .tag_out (tag_c[k+1]),
            .x_out   (x_c[k+1]),
            .t_out   (t_c[k+1])
        );
    end

    bcy_poly #(
        .F (F)
    ) u_poly (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .rev     (rev_reg),
        .tag_in  (tag_c[F]),
        .x_in    (x_c[F]),
        .t_in    (t_c[F]),
        .vld_out (out_valid),
        .y_out   (y_value),
        .t_out   (t_param)
    );

endmodule
